[hw/rtl/rrts_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared types and constants for the round robin thread slot scheduler.
// ----------------------------------------------------------------------------
package rrts_pkg;

   localparam int unsigned THREAD_SLOTS = 16;
   localparam int unsigned STACK_BYTES  = 1048576;
   localparam int unsigned SLOT_W       = $clog2(THREAD_SLOTS);
   localparam int unsigned CNT_W        = SLOT_W + 1;

   localparam logic [31:0] TID_RESET     = 32'h0000_1000;
   localparam logic [31:0] HANDLE_RESET  = 32'h0000_7100;
   localparam logic [31:0] EXIT_ACTIVE   = 32'd259;
   localparam logic [63:0] STACK_RESET   = 64'h0000_0000_6000_0000;
   localparam logic [63:0] STACK_STRIDE  = 64'(STACK_BYTES) + 64'h1000;
   localparam logic [63:0] SP_OFFSET     = 64'(STACK_BYTES) - 64'h100;

   typedef enum logic [2:0] {
      ST_FREE      = 3'd0,
      ST_READY     = 3'd1,
      ST_RUNNING   = 3'd2,
      ST_WAITING   = 3'd3,
      ST_SUSPENDED = 3'd4,
      ST_EXITED    = 3'd5
   } slot_state_type;

   typedef enum logic [2:0] {
      REQ_CREATE = 3'd0,
      REQ_YIELD  = 3'd1,
      REQ_WAKE   = 3'd2,
      REQ_EXIT   = 3'd3,
      REQ_FIND   = 3'd4
   } req_kind_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_PREP,
      FSM_SCAN,
      FSM_SETTLE,
      FSM_OTHER,
      FSM_DONE
   } fsm_type;

   typedef struct packed {
      logic [2:0]  req_type;
      logic        start_suspended;
      logic [2:0]  yield_state;
      logic [31:0] handle;
      logic [31:0] exit_value;
   } req_type_type;

   typedef struct packed {
      logic        ok;
      logic [3:0]  slot;
      logic [31:0] thread_id;
      logic [31:0] thread_handle;
      logic [63:0] stack_addr;
      logic [63:0] initial_sp;
      logic        current_valid;
      logic [3:0]  current_slot;
      logic [31:0] current_tid;
      logic        other_ready;
      logic [2:0]  entry_state;
      logic [31:0] entry_exit_code;
   } rsp_type_type;

endpackage
`default_nettype wire

[hw/rtl/rrts_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rrts_req_if / rrts_rsp_if
// Valid/ready channels carrying a scheduler request and its response.
// ----------------------------------------------------------------------------
interface rrts_req_if;
   import rrts_pkg::*;
   logic         valid;
   logic         ready;
   req_type_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface rrts_rsp_if;
   import rrts_pkg::*;
   logic         valid;
   logic         ready;
   rsp_type_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

[hw/rtl/round_robin_thread_slot_scheduler.sv]
`default_nettype none
// Sequence: after a request is accepted, a prep step, a scan that stops at its
//   first hit (wake always visits all slots), a settle step and a status sweep
//   over all slots run before the response goes valid.
// Flow: one request at a time; the next is taken only after the
//   response is accepted.
// Reset: synchronous, active high; all slots free, no current thread.
// ----------------------------------------------------------------------------
// round_robin_thread_slot_scheduler
// Thread slot table with create, yield, wake, exit and find requests,
// serviced by one slot compare unit stepped by a small sequencer.
// ----------------------------------------------------------------------------
module round_robin_thread_slot_scheduler (
   input  wire          clock,
   input  wire          reset,
   input  wire          csr_we,
   input  wire [63:0]   csr_wdata,
   rrts_req_if.sink     req,
   rrts_rsp_if.source   rsp
);
   import rrts_pkg::*;

   // slot table, one entry visited per cycle
   logic [2:0]  slot_state_ff [THREAD_SLOTS];
   logic [31:0] slot_id_ff    [THREAD_SLOTS];
   logic [31:0] slot_hnd_ff   [THREAD_SLOTS];
   logic [31:0] slot_wait_ff  [THREAD_SLOTS];
   logic [31:0] slot_exit_ff  [THREAD_SLOTS];

   logic              cur_valid_ff;
   logic [SLOT_W-1:0] cur_idx_ff;
   logic [31:0]       next_tid_ff;
   logic [31:0]       next_hnd_ff;
   logic [63:0]       next_stack_ff;

   fsm_type           state_ff, state_in;
   req_type_type      r_ff;
   logic [CNT_W-1:0]  cnt_ff;       // steps taken in a sweep
   logic [SLOT_W-1:0] idx_ff;       // slot under the shared unit
   logic              hit_ff;       // sweep found its slot
   logic [SLOT_W-1:0] hit_idx_ff;
   logic              exit_live_ff; // exit request had a current thread
   logic              rsp_valid_ff;
   rsp_type_type      rsp_ff;

   // shared compare unit: looks at the slot under idx_ff
   logic [2:0]  u_state;
   logic        u_match;
   always_comb begin
      u_state = slot_state_ff[idx_ff];
      case (r_ff.req_type)
         REQ_CREATE: u_match = (u_state == ST_FREE);
         REQ_WAKE:   u_match = (u_state == ST_WAITING) &&
                               (slot_wait_ff[idx_ff] == r_ff.handle);
         REQ_FIND:   u_match = (u_state != ST_FREE) &&
                               (slot_hnd_ff[idx_ff] == r_ff.handle);
         default:    u_match = (u_state == ST_READY);
      endcase
   end

   logic scan_last;
   assign scan_last = (cnt_ff == CNT_W'(THREAD_SLOTS - 1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE:   if (req.valid && !rsp_valid_ff) state_in = FSM_PREP;
         FSM_PREP:   state_in = FSM_SCAN;
         FSM_SCAN:   if (scan_last || (u_match && r_ff.req_type != REQ_WAKE))
                        state_in = FSM_SETTLE;
         FSM_SETTLE: state_in = FSM_OTHER;
         FSM_OTHER:  if (scan_last) state_in = FSM_DONE;
         FSM_DONE:   state_in = FSM_IDLE;
         default:    state_in = FSM_IDLE;
      endcase
   end

   assign req.ready = (state_ff == FSM_IDLE) && !rsp_valid_ff;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.payload = rsp_ff;

   logic [2:0] nst_sat;
   assign nst_sat = (r_ff.yield_state > 3'(ST_EXITED)) ? 3'(ST_EXITED) : r_ff.yield_state;

   logic [63:0] sp_sum;
   assign sp_sum = next_stack_ff + SP_OFFSET;

   // a real request for the scan (unknown request types do nothing);
   // exit has already cleared the current thread by the time it scans
   logic active;
   assign active = (r_ff.req_type == REQ_CREATE) || (r_ff.req_type == REQ_WAKE) ||
                   (r_ff.req_type == REQ_FIND) ||
                   (r_ff.req_type == REQ_YIELD) ||
                   (r_ff.req_type == REQ_EXIT && exit_live_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= FSM_IDLE;
         rsp_valid_ff  <= 1'b0;
         cur_valid_ff  <= 1'b0;
         cur_idx_ff    <= '0;
         next_tid_ff   <= TID_RESET;
         next_hnd_ff   <= HANDLE_RESET;
         next_stack_ff <= STACK_RESET;
         for (int i = 0; i < THREAD_SLOTS; i++) begin
            slot_state_ff[i] <= 3'(ST_FREE);
            slot_id_ff[i]    <= '0;
            slot_hnd_ff[i]   <= '0;
            slot_wait_ff[i]  <= '0;
            slot_exit_ff[i]  <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (rsp_valid_ff && rsp.ready) rsp_valid_ff <= 1'b0;
         if (csr_we) next_stack_ff <= csr_wdata;
         case (state_ff)
            FSM_IDLE: begin
               if (req.valid && !rsp_valid_ff) r_ff <= req.payload;
            end
            FSM_PREP: begin
               // store the current slot's new state and choose scan start
               cnt_ff <= '0;
               hit_ff <= 1'b0;
               rsp_ff <= '0;
               idx_ff <= '0;
               exit_live_ff <= cur_valid_ff;
               if (r_ff.req_type == REQ_YIELD && cur_valid_ff) begin
                  slot_state_ff[cur_idx_ff] <= nst_sat;
                  slot_wait_ff[cur_idx_ff]  <= (nst_sat == 3'(ST_WAITING)) ?
                                               r_ff.handle : 32'd0;
                  idx_ff <= cur_idx_ff + SLOT_W'(1);
               end else if (r_ff.req_type == REQ_EXIT && cur_valid_ff) begin
                  slot_state_ff[cur_idx_ff] <= 3'(ST_EXITED);
                  slot_exit_ff[cur_idx_ff]  <= r_ff.exit_value;
                  cur_valid_ff <= 1'b0;
                  cur_idx_ff   <= '0;
               end
            end
            FSM_SCAN: begin
               cnt_ff <= cnt_ff + CNT_W'(1);
               idx_ff <= idx_ff + SLOT_W'(1);
               if (u_match && active) begin
                  if (r_ff.req_type == REQ_WAKE) begin
                     slot_state_ff[idx_ff] <= 3'(ST_READY);
                     slot_wait_ff[idx_ff]  <= '0;
                  end else if (!hit_ff) begin
                     hit_ff     <= 1'b1;
                     hit_idx_ff <= idx_ff;
                  end
               end
            end
            FSM_SETTLE: begin
               // apply the outcome of the scan
               cnt_ff <= '0;
               idx_ff <= '0;
               case (r_ff.req_type)
                  REQ_CREATE: if (hit_ff) begin
                     slot_id_ff[hit_idx_ff]    <= next_tid_ff;
                     slot_hnd_ff[hit_idx_ff]   <= next_hnd_ff;
                     slot_wait_ff[hit_idx_ff]  <= '0;
                     slot_exit_ff[hit_idx_ff]  <= EXIT_ACTIVE;
                     slot_state_ff[hit_idx_ff] <= r_ff.start_suspended ?
                                                  3'(ST_SUSPENDED) : 3'(ST_READY);
                     next_tid_ff   <= next_tid_ff + 32'd1;
                     next_hnd_ff   <= next_hnd_ff + 32'd1;
                     next_stack_ff <= next_stack_ff + STACK_STRIDE;
                     rsp_ff.ok            <= 1'b1;
                     rsp_ff.slot          <= 4'(hit_idx_ff);
                     rsp_ff.thread_id     <= next_tid_ff;
                     rsp_ff.thread_handle <= next_hnd_ff;
                     rsp_ff.stack_addr    <= next_stack_ff;
                     rsp_ff.initial_sp    <= {sp_sum[63:4], 4'h0} - 64'd8;
                  end
                  REQ_YIELD, REQ_EXIT: begin
                     if (hit_ff && active) begin
                        slot_state_ff[hit_idx_ff] <= 3'(ST_RUNNING);
                        cur_valid_ff <= 1'b1;
                        cur_idx_ff   <= hit_idx_ff;
                        rsp_ff.ok    <= 1'b1;
                        rsp_ff.slot  <= 4'(hit_idx_ff);
                     end else if (r_ff.req_type == REQ_YIELD && cur_valid_ff) begin
                        slot_state_ff[cur_idx_ff] <= 3'(ST_RUNNING);
                     end
                  end
                  REQ_FIND: if (hit_ff) begin
                     rsp_ff.ok              <= 1'b1;
                     rsp_ff.slot            <= 4'(hit_idx_ff);
                     rsp_ff.thread_id       <= slot_id_ff[hit_idx_ff];
                     rsp_ff.entry_state     <= slot_state_ff[hit_idx_ff];
                     rsp_ff.entry_exit_code <= slot_exit_ff[hit_idx_ff];
                  end
                  default: ;
               endcase
            end
            FSM_OTHER: begin
               // status sweep: any ready slot other than the current one
               cnt_ff <= cnt_ff + CNT_W'(1);
               idx_ff <= idx_ff + SLOT_W'(1);
               if (u_state == ST_READY && !(cur_valid_ff && idx_ff == cur_idx_ff))
                  rsp_ff.other_ready <= 1'b1;
            end
            FSM_DONE: begin
               rsp_ff.current_valid <= cur_valid_ff;
               rsp_ff.current_slot  <= cur_valid_ff ? 4'(cur_idx_ff) : 4'd0;
               rsp_ff.current_tid   <= cur_valid_ff ? slot_id_ff[cur_idx_ff] : 32'd0;
               rsp_valid_ff <= 1'b1;
            end
            default: ;
         endcase
      end
   end
endmodule
`default_nettype wire

[tb/round_robin_thread_slot_scheduler_test.sv]
`timescale 1ns / 100ps
`default_nettype none
// ----------------------------------------------------------------------------
// round_robin_thread_slot_scheduler_test
// Drives create, yield, wake, exit and find requests with random gaps and
// stalls, predicts every response from a local copy of the slot table and
// compares each whole response with it.
// ----------------------------------------------------------------------------
module round_robin_thread_slot_scheduler_test;
   import rrts_pkg::*;

   localparam int MAX_QUIET = 20000;   // cycles without any handshake
   localparam int DRAIN     = 60;      // longer than one request latency

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [63:0] csr_wdata;

   rrts_req_if req ();
   rrts_rsp_if rsp ();

   round_robin_thread_slot_scheduler dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req       (req.sink),
      .rsp       (rsp.source)
   );

   always begin
      clock = 1'b1; #2;
      clock = 1'b0; #2;
   end

   // ---- predicted scheduler state -----------------------------------------
   slot_state_type sched_state [THREAD_SLOTS];
   logic [31:0]    sched_id    [THREAD_SLOTS];
   logic [31:0]    sched_handle[THREAD_SLOTS];
   logic [31:0]    sched_wait  [THREAD_SLOTS];
   logic [31:0]    sched_exit  [THREAD_SLOTS];
   logic           run_valid;
   logic [3:0]     run_slot;
   logic [31:0]    tid_next;
   logic [31:0]    handle_next;
   logic [63:0]    stack_next;

   rsp_type_type expected_rsps[$];
   int  mismatches = 0;
   int  quiet      = 0;
   bit  rsp_gap_off = 0;  // receiver stalls off for part of the run

   function automatic void clear_table(logic [63:0] region);
      for (int i = 0; i < THREAD_SLOTS; i++) begin
         sched_state[i]  = ST_FREE;
         sched_id[i]     = '0;
         sched_handle[i] = '0;
         sched_wait[i]   = '0;
         sched_exit[i]   = '0;
      end
      run_valid   = 1'b0;
      run_slot    = '0;
      tid_next    = TID_RESET;
      handle_next = HANDLE_RESET;
      stack_next  = region;
   endfunction

   // round robin pick of a ready slot from start; makes it current
   function automatic bit pick_ready(int start, output logic [3:0] got);
      int idx;
      got = '0;
      for (int i = 0; i < THREAD_SLOTS; i++) begin
         idx = (start + i) % THREAD_SLOTS;
         if (sched_state[idx] == ST_READY) begin
            run_valid        = 1'b1;
            run_slot         = idx[3:0];
            sched_state[idx] = ST_RUNNING;
            got              = idx[3:0];
            return 1;
         end
      end
      return 0;
   endfunction

   function automatic rsp_type_type predict_schedule(req_type_type r);
      rsp_type_type   o;
      logic [3:0]     got;
      logic [2:0]     ns;
      int             f;
      int             start;
      o = '0;
      case (r.req_type)
         REQ_CREATE: begin
            f = -1;
            for (int i = THREAD_SLOTS - 1; i >= 0; i--)
               if (sched_state[i] == ST_FREE) f = i;
            if (f >= 0) begin
               sched_id[f]     = tid_next;
               sched_handle[f] = handle_next;
               tid_next++;
               handle_next++;
               sched_wait[f]   = '0;
               sched_exit[f]   = EXIT_ACTIVE;
               o.stack_addr    = stack_next;
               stack_next      = stack_next + STACK_STRIDE;
               o.initial_sp    = ((o.stack_addr + SP_OFFSET) & ~64'hF) - 64'd8;
               sched_state[f]  = r.start_suspended ? ST_SUSPENDED : ST_READY;
               o.ok            = 1'b1;
               o.slot          = f[3:0];
               o.thread_id     = sched_id[f];
               o.thread_handle = sched_handle[f];
            end
         end
         REQ_YIELD: begin
            start = 0;
            if (run_valid) begin
               ns = (r.yield_state > ST_EXITED) ? ST_EXITED : r.yield_state;
               sched_state[run_slot] = slot_state_type'(ns);
               sched_wait[run_slot]  = (ns == ST_WAITING) ? r.handle : '0;
               start = run_slot + 1;
            end
            if (pick_ready(start, got)) begin
               o.ok   = 1'b1;
               o.slot = got;
            end else if (run_valid) begin
               sched_state[run_slot] = ST_RUNNING;
            end
         end
         REQ_WAKE: begin
            for (int i = 0; i < THREAD_SLOTS; i++)
               if (sched_state[i] == ST_WAITING && sched_wait[i] == r.handle) begin
                  sched_state[i] = ST_READY;
                  sched_wait[i]  = '0;
               end
         end
         REQ_EXIT: begin
            if (run_valid) begin
               sched_state[run_slot] = ST_EXITED;
               sched_exit[run_slot]  = r.exit_value;
               run_valid = 1'b0;
               run_slot  = '0;
               if (pick_ready(0, got)) begin
                  o.ok   = 1'b1;
                  o.slot = got;
               end
            end
         end
         REQ_FIND: begin
            for (int i = 0; i < THREAD_SLOTS; i++)
               if (sched_handle[i] == r.handle && sched_state[i] != ST_FREE) begin
                  o.ok              = 1'b1;
                  o.slot            = i[3:0];
                  o.thread_id       = sched_id[i];
                  o.entry_state     = sched_state[i];
                  o.entry_exit_code = sched_exit[i];
                  break;
               end
         end
         default: ;  // unused request codes: status only
      endcase
      o.current_valid = run_valid;
      o.current_slot  = run_valid ? run_slot : '0;
      o.current_tid   = run_valid ? sched_id[run_slot] : '0;
      for (int i = 0; i < THREAD_SLOTS; i++)
         if ((!run_valid || i != run_slot) && sched_state[i] == ST_READY)
            o.other_ready = 1'b1;
      return o;
   endfunction

   // ---- request driver ----------------------------------------------------
   // valid stays high after a request is taken unless a gap follows;
   // wait_idle drops it when the sender stops
   task automatic send_request(logic [2:0] kind, logic susp, logic [2:0] ns,
                               logic [31:0] hnd, logic [31:0] code);
      int gap;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid   <= 1'b1;
      req.payload <= '{kind, susp, ns, hnd, code};
      do @(posedge clock); while (!req.ready);
      // request taken at this edge
      expected_rsps.push_back(predict_schedule(req.payload));
   endtask

   task automatic wait_idle();
      req.valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   task automatic write_region(logic [63:0] v);
      wait_idle();
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      clear_region(v);
   endtask

   // a write only moves the stack cursor; the table is untouched
   function automatic void clear_region(logic [63:0] v);
      stack_next = v;
   endfunction

   // ---- response checker --------------------------------------------------
   initial begin
      int stall;
      rsp.ready = 1'b0;
      @(negedge reset);
      forever begin
         stall = rsp_gap_off ? 0 : $urandom_range(0, 14);
         if (stall > 0) begin
            rsp.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         do @(posedge clock); while (!rsp.valid);
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %p", rsp.payload);
         end else begin
            rsp_type_type e;
            e = expected_rsps.pop_front();
            if (rsp.payload !== e) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("response mismatch\n  exp %p\n  got %p", e, rsp.payload);
            end
         end
      end
   end

   // watchdog: cycles without any handshake
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || csr_we)
         quiet <= 0;
      else
         quiet <= quiet + 1;
      if (quiet >= MAX_QUIET) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // ---- test tasks --------------------------------------------------------
   task automatic test_directed();
      // find on an empty table, yield and exit with nothing current
      send_request(REQ_FIND,  0, 0, HANDLE_RESET, 0);
      send_request(REQ_YIELD, 0, ST_READY, 0, 0);
      send_request(REQ_EXIT,  0, 0, 0, 32'hFFFF_FFFF);
      // create both kinds, pick one up, wait on a handle and wake it
      send_request(REQ_CREATE, 0, 0, 0, 0);
      send_request(REQ_CREATE, 1, 0, 0, 0);
      send_request(REQ_CREATE, 0, 7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(REQ_YIELD, 0, ST_READY, 0, 0);
      send_request(REQ_YIELD, 0, ST_WAITING, 32'hFFFF_FFFF, 0);
      send_request(REQ_WAKE,  0, 0, 32'hFFFF_FFFE, 0);
      send_request(REQ_WAKE,  0, 0, 32'hFFFF_FFFF, 0);
      // saturating states
      send_request(REQ_YIELD, 0, 3'd7, 0, 0);
      send_request(REQ_YIELD, 0, 3'd6, 0, 0);
      send_request(REQ_YIELD, 0, ST_SUSPENDED, 0, 0);
      send_request(REQ_EXIT,  0, 0, 0, 32'h8000_0001);
      send_request(REQ_FIND,  0, 0, HANDLE_RESET, 0);
      send_request(REQ_FIND,  0, 0, HANDLE_RESET + 1, 0);
      // unused request codes
      send_request(3'd5, 1, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(3'd6, 0, 0, 0, 0);
      send_request(3'd7, 1, 0, 0, 0);
   endtask

   task automatic test_table_full();
      // fill the free slots; the creates beyond them fail
      repeat (THREAD_SLOTS + 1)
         send_request(REQ_CREATE, 1'($urandom_range(0, 1)), 0, 0, 0);
   endtask

   task automatic test_random(int count);
      logic [2:0]  kind;
      logic [31:0] hnd;
      int          pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         // mostly meaningful handles so wake and find hit live slots
         hnd = ($urandom_range(0, 3) != 0) ? handle_next - $urandom_range(1, 24)
                                           : $urandom;
         if      (pick < 20) kind = REQ_CREATE;
         else if (pick < 55) kind = REQ_YIELD;
         else if (pick < 70) kind = REQ_WAKE;
         else if (pick < 80) kind = REQ_EXIT;
         else if (pick < 96) kind = REQ_FIND;
         else                kind = 3'($urandom_range(5, 7));
         if (kind == REQ_WAKE && $urandom_range(0, 1)) begin
            // wake the handle that a random slot waits on, if any
            int s = $urandom_range(0, THREAD_SLOTS - 1);
            hnd = sched_wait[s];
         end
         if (kind == REQ_YIELD && $urandom_range(0, 2) == 0) hnd = $urandom;
         send_request(kind, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), hnd,
                      $urandom);
      end
   endtask

   task automatic test_drain_pause();
      // sender holds off until every response is back
      wait_idle();
      send_request(REQ_YIELD, 0, ST_READY, 0, 0);
   endtask

   // ---- sequence ----------------------------------------------------------
   initial begin
      reset       = 1'b1;
      csr_we      = 1'b0;
      csr_wdata   = '0;
      req.valid   = 1'b0;
      req.payload = '0;
      clear_table(STACK_RESET);
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_table_full();
      write_region(64'hFFFF_FFFF_FFFF_F000);   // wraps past the top
      test_random(120);
      test_drain_pause();
      write_region(64'h0);
      rsp_gap_off = 1;
      test_random(120);
      rsp_gap_off = 0;
      write_region({$urandom, $urandom});
      test_random(130);
      write_region(64'hA5A5_5A5A_0F0F_F0F7);
      test_random(130);

      wait_idle();
      if (mismatches == 0 && expected_rsps.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
`default_nettype wire
